// File: rtl/ahld_pkg.sv
// shared types and constants for the axis homing and limited drive block
// no dependencies
`default_nettype none

package ahld_pkg;

    localparam int CMD_W      = 16;
    localparam int POS_W      = 16;
    localparam int SPEED_W    = 13;
    localparam int COUNT_W    = 15;
    localparam int COMPARE_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // pwm compare multiplier, valid range 1..8 keeps the compare in 16 bits
    localparam logic [3:0] COMPARE_SCALE = 4'd5;

    localparam logic [SPEED_W-1:0] DRIVE_LIMIT_RESET      = 13'd8000;
    localparam logic [SPEED_W-1:0] HOMING_SPEED_RESET     = 13'd3000;
    localparam logic [COUNT_W-1:0] OVERSHOOT_COUNTS_RESET = 15'd50;
    localparam logic [COUNT_W-1:0] BACKOFF_COUNTS_RESET   = 15'd300;

    typedef enum logic [1:0] {
        PH_JOG       = 2'd0,
        PH_OVERSHOOT = 2'd1,
        PH_RETURN    = 2'd2,
        PH_BACKOFF   = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRIVE_LIMIT      = 3'd0,
        REG_HOMING_SPEED     = 3'd1,
        REG_OVERSHOOT_COUNTS = 3'd2,
        REG_BACKOFF_COUNTS   = 3'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/axis_homing_and_limited_drive_top.sv
// axis homing sequencer and limited drive stage, top level
// depends on ahld_pkg
`default_nettype none

// path from input request to result: input register, then result register
// throughput: one request per cycle; the result register holds the drive state,
// so a new request moves forward whenever the result is free or being taken
// reset: asynchronous active low, clears homing, blocks, holds and both valids,
// and loads the configuration registers with their default values
module axis_homing_and_limited_drive_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [ahld_pkg::CMD_W-1:0] motor_command,
    input  wire logic                             drive_enable,
    input  wire logic                             home_sensor,
    input  wire logic                             pos_limit_sensor,
    input  wire logic                             neg_limit_sensor,
    input  wire logic signed [ahld_pkg::POS_W-1:0] position,
    input  wire logic                             home_request,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  direction_forward,
    output logic [ahld_pkg::COMPARE_W-1:0]        compare_value,
    output logic                                  zero_position,
    output logic                                  homing_busy,
    output logic                                  homing_finished,
    output logic                                  pos_blocked,
    output logic                                  neg_blocked,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ahld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ahld_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ahld_pkg::*;

    // configuration registers
    logic [SPEED_W-1:0] drive_limit_reg;
    logic [SPEED_W-1:0] homing_speed_reg;
    logic [COUNT_W-1:0] overshoot_counts_reg;
    logic [COUNT_W-1:0] backoff_counts_reg;

    // input register
    logic                     in_valid_reg;
    logic signed [CMD_W-1:0]  cmd_reg;
    logic                     enable_reg;
    logic                     home_reg;
    logic                     plim_reg;
    logic                     nlim_reg;
    logic signed [POS_W-1:0]  pos_reg;
    logic                     req_reg;

    // block state; these registers are also the result payload
    logic                 out_valid_reg;
    logic                 homing_active_reg;
    phase_t               phase_reg;
    logic                 pos_block_reg;
    logic                 neg_block_reg;
    logic [COMPARE_W-1:0] compare_hold_reg;
    logic                 direction_hold_reg;
    logic                 zero_reg;
    logic                 finished_reg;

    logic                 homing_active_next;
    phase_t               phase_next;
    logic                 pos_block_next;
    logic                 neg_block_next;
    logic [COMPARE_W-1:0] compare_hold_next;
    logic                 direction_hold_next;
    logic                 zero_next;
    logic                 finished_next;

    logic   advance;      // request in the input register moves to the result
    logic   active_start; // homing active at the start of this tick
    phase_t phase_start;

    logic signed [CMD_W:0]   cmd_eff;   // one extra bit holds -speed and -limit
    logic signed [CMD_W:0]   lim_s;
    logic signed [CMD_W:0]   abs_cmd;
    logic [SPEED_W-1:0]      mag;
    logic [SPEED_W+3:0]      product;
    logic signed [POS_W:0]   pos_ext;
    logic signed [POS_W:0]   overshoot_s;
    logic signed [POS_W:0]   backoff_neg_s;
    logic signed [CMD_W:0]   speed_s;

    assign cfg_ready = 1'b1;

    // handshake: result register frees when empty or taken this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_limit_reg      <= DRIVE_LIMIT_RESET;
            homing_speed_reg     <= HOMING_SPEED_RESET;
            overshoot_counts_reg <= OVERSHOOT_COUNTS_RESET;
            backoff_counts_reg   <= BACKOFF_COUNTS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DRIVE_LIMIT:      drive_limit_reg      <= cfg_data[SPEED_W-1:0];
                REG_HOMING_SPEED:     homing_speed_reg     <= cfg_data[SPEED_W-1:0];
                REG_OVERSHOOT_COUNTS: overshoot_counts_reg <= cfg_data[COUNT_W-1:0];
                REG_BACKOFF_COUNTS:   backoff_counts_reg   <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register, loads whenever it is empty or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg    <= motor_command;
            enable_reg <= drive_enable;
            home_reg   <= home_sensor;
            plim_reg   <= pos_limit_sensor;
            nlim_reg   <= neg_limit_sensor;
            pos_reg    <= position;
            req_reg    <= home_request;
        end
    end

    // a homing request while idle starts at the jog phase, evaluated this same tick
    assign active_start = homing_active_reg || req_reg;
    assign phase_start  = (req_reg && !homing_active_reg) ? PH_JOG : phase_reg;

    assign pos_ext       = {pos_reg[POS_W-1], pos_reg};
    assign overshoot_s   = {2'b00, overshoot_counts_reg};
    assign backoff_neg_s = -$signed({2'b00, backoff_counts_reg});
    assign speed_s       = {{(CMD_W+1-SPEED_W){1'b0}}, homing_speed_reg};

    // homing sequencer: next phase and activity
    always_comb
    begin
        homing_active_next = active_start;
        phase_next         = phase_start;
        if (active_start)
        begin
            case (phase_start)
                PH_JOG:
                begin
                    if (home_reg)
                        phase_next = PH_OVERSHOOT;
                    else if (plim_reg)
                        phase_next = PH_BACKOFF;
                end
                PH_OVERSHOOT:
                begin
                    if (pos_ext >= overshoot_s)
                        phase_next = PH_RETURN;
                end
                PH_RETURN:
                begin
                    if (home_reg)
                    begin
                        homing_active_next = 1'b0;
                        phase_next         = PH_JOG;
                    end
                end
                PH_BACKOFF:
                begin
                    if (pos_ext <= backoff_neg_s)
                        phase_next = PH_RETURN;
                end
                default: ;
            endcase
        end
    end

    // homing sequencer: command override and pulses
    always_comb
    begin
        cmd_eff       = {cmd_reg[CMD_W-1], cmd_reg};
        zero_next     = 1'b0;
        finished_next = 1'b0;
        if (active_start)
        begin
            case (phase_start)
                PH_JOG:
                begin
                    cmd_eff   = speed_s;
                    zero_next = home_reg || plim_reg;
                end
                PH_OVERSHOOT:
                begin
                    cmd_eff = speed_s;
                end
                PH_RETURN:
                begin
                    // finishing tick drives a zero command
                    if (home_reg)
                    begin
                        cmd_eff       = '0;
                        zero_next     = 1'b1;
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        cmd_eff = -speed_s;
                    end
                end
                PH_BACKOFF:
                begin
                    cmd_eff = -speed_s;
                end
                default: ;
            endcase
        end
    end

    // drive stage: clamp magnitude, latch direction blocks
    assign lim_s   = {{(CMD_W+1-SPEED_W){1'b0}}, drive_limit_reg};
    assign abs_cmd = cmd_eff[CMD_W] ? -cmd_eff : cmd_eff;

    always_comb
    begin
        direction_hold_next = direction_hold_reg;
        pos_block_next      = pos_block_reg;
        neg_block_next      = neg_block_reg;
        compare_hold_next   = compare_hold_reg;
        mag                 = '0;
        product             = '0;
        if (enable_reg)
        begin
            // zero command counts as forward
            if (!cmd_eff[CMD_W])
            begin
                direction_hold_next = 1'b1;
                neg_block_next      = 1'b0;
                if (plim_reg || pos_block_reg)
                    pos_block_next = 1'b1;
            end
            else
            begin
                direction_hold_next = 1'b0;
                pos_block_next      = 1'b0;
                if (nlim_reg || neg_block_reg)
                    neg_block_next = 1'b1;
            end
            if ((!cmd_eff[CMD_W] && (plim_reg || pos_block_reg))
                || (cmd_eff[CMD_W] && (nlim_reg || neg_block_reg)))
                mag = '0;
            else if (abs_cmd > lim_s)
                mag = drive_limit_reg;
            else
                mag = abs_cmd[SPEED_W-1:0];
            product           = {4'b0000, mag} * {{SPEED_W{1'b0}}, COMPARE_SCALE};
            compare_hold_next = product[COMPARE_W-1:0];
        end
    end

    // result register and block state commit together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg      <= 1'b0;
            homing_active_reg  <= 1'b0;
            phase_reg          <= PH_JOG;
            pos_block_reg      <= 1'b0;
            neg_block_reg      <= 1'b0;
            compare_hold_reg   <= '0;
            direction_hold_reg <= 1'b0;
            zero_reg           <= 1'b0;
            finished_reg       <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                homing_active_reg  <= homing_active_next;
                phase_reg          <= phase_next;
                pos_block_reg      <= pos_block_next;
                neg_block_reg      <= neg_block_next;
                compare_hold_reg   <= compare_hold_next;
                direction_hold_reg <= direction_hold_next;
                zero_reg           <= zero_next;
                finished_reg       <= finished_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign direction_forward = direction_hold_reg;
    assign compare_value     = compare_hold_reg;
    assign zero_position     = zero_reg;
    assign homing_busy       = homing_active_reg;
    assign homing_finished   = finished_reg;
    assign pos_blocked       = pos_block_reg;
    assign neg_blocked       = neg_block_reg;

endmodule

`default_nettype wire

// File: tb/axis_homing_and_limited_drive_top_test.sv
// self-checking testbench for the axis homing and limited drive block
// predicts every result from an internal model of homing and drive state
// depends on ahld_pkg and axis_homing_and_limited_drive_top
module axis_homing_and_limited_drive_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ahld_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    // result register plus input register, with margin
    localparam int DRAIN_SETTLE   = 8;

    // one control tick as seen on the input channel
    typedef struct {
        logic signed [CMD_W-1:0] motor_command;
        logic                    drive_enable;
        logic                    home_sensor;
        logic                    pos_limit_sensor;
        logic                    neg_limit_sensor;
        logic signed [POS_W-1:0] position;
        logic                    home_request;
    } axis_tick_t;

    // drive and homing status returned for each tick
    typedef struct {
        logic                 dir_fwd;
        logic [COMPARE_W-1:0] compare;
        logic                 zero;
        logic                 busy;
        logic                 finished;
        logic                 pos_blk;
        logic                 neg_blk;
    } drive_status_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // block inputs, all known from time zero
    logic                    in_valid         = 1'b0;
    logic signed [CMD_W-1:0] motor_command    = '0;
    logic                    drive_enable     = 1'b0;
    logic                    home_sensor      = 1'b0;
    logic                    pos_limit_sensor = 1'b0;
    logic                    neg_limit_sensor = 1'b0;
    logic signed [POS_W-1:0] position         = '0;
    logic                    home_request     = 1'b0;
    logic                    out_stall        = 1'b0;
    logic                    cfg_valid        = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index        = REG_DRIVE_LIMIT;
    logic [CFG_DATA_W-1:0]   cfg_data         = '0;

    // block outputs
    logic                 in_stall;
    logic                 out_valid;
    logic                 direction_forward;
    logic [COMPARE_W-1:0] compare_value;
    logic                 zero_position;
    logic                 homing_busy;
    logic                 homing_finished;
    logic                 pos_blocked;
    logic                 neg_blocked;
    logic                 cfg_ready;

    axis_homing_and_limited_drive_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .motor_command    (motor_command),
        .drive_enable     (drive_enable),
        .home_sensor      (home_sensor),
        .pos_limit_sensor (pos_limit_sensor),
        .neg_limit_sensor (neg_limit_sensor),
        .position         (position),
        .home_request     (home_request),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .direction_forward(direction_forward),
        .compare_value    (compare_value),
        .zero_position    (zero_position),
        .homing_busy      (homing_busy),
        .homing_finished  (homing_finished),
        .pos_blocked      (pos_blocked),
        .neg_blocked      (neg_blocked),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // model copy of the configuration registers, reset values from the package
    logic [SPEED_W-1:0] drive_limit_q  = DRIVE_LIMIT_RESET;
    logic [SPEED_W-1:0] homing_speed_q = HOMING_SPEED_RESET;
    logic [COUNT_W-1:0] overshoot_q    = OVERSHOOT_COUNTS_RESET;
    logic [COUNT_W-1:0] backoff_q      = BACKOFF_COUNTS_RESET;

    // model copy of the homing sequencer and drive stage state
    logic                 homing_on    = 1'b0;
    phase_t               axis_phase   = PH_JOG;
    logic                 pos_latch    = 1'b0;
    logic                 neg_latch    = 1'b0;
    logic [COMPARE_W-1:0] compare_hold = '0;
    logic                 dir_hold     = 1'b0;

    // status words still owed by the block, oldest first
    drive_status_t pending_status[$];
    int            mismatches = 0;
    // when set, neither side inserts gaps or stalls
    logic          no_idle    = 1'b0;

    // advance the model by one tick and return the status it should report
    function automatic drive_status_t step_axis(input axis_tick_t t);
        drive_status_t s;
        int            cmd;
        int            pos;
        int            speed;
        int            lim;
        int            mag;
        logic          zero;
        logic          done;

        cmd   = int'(t.motor_command);
        pos   = int'(t.position);
        speed = int'(homing_speed_q);
        lim   = int'(drive_limit_q);
        zero  = 1'b0;
        done  = 1'b0;

        // a request only starts a new sequence, jog is evaluated right away
        if (t.home_request && !homing_on)
        begin
            homing_on  = 1'b1;
            axis_phase = PH_JOG;
        end

        if (homing_on)
        begin
            case (axis_phase)
                PH_JOG:
                begin
                    cmd = speed;
                    if (t.home_sensor)
                    begin
                        zero       = 1'b1;
                        axis_phase = PH_OVERSHOOT;
                    end
                    else if (t.pos_limit_sensor)
                    begin
                        zero       = 1'b1;
                        axis_phase = PH_BACKOFF;
                    end
                end
                PH_OVERSHOOT:
                begin
                    cmd = speed;
                    if (pos >= int'(overshoot_q))
                        axis_phase = PH_RETURN;
                end
                PH_RETURN:
                begin
                    cmd = -speed;
                    if (t.home_sensor)
                    begin
                        cmd        = 0;
                        zero       = 1'b1;
                        done       = 1'b1;
                        homing_on  = 1'b0;
                        axis_phase = PH_JOG;
                    end
                end
                default:
                begin
                    cmd = -speed;
                    if (pos <= -int'(backoff_q))
                        axis_phase = PH_RETURN;
                end
            endcase
        end

        // drive stage, frozen when disabled
        if (t.drive_enable)
        begin
            if (cmd >= 0)
            begin
                dir_hold  = 1'b1;
                neg_latch = 1'b0;
                if (cmd > lim)
                    cmd = lim;
                if (t.pos_limit_sensor || pos_latch)
                begin
                    cmd       = 0;
                    pos_latch = 1'b1;
                end
                mag = cmd;
            end
            else
            begin
                dir_hold  = 1'b0;
                pos_latch = 1'b0;
                if (cmd < -lim)
                    cmd = -lim;
                if (t.neg_limit_sensor || neg_latch)
                begin
                    cmd       = 0;
                    neg_latch = 1'b1;
                end
                mag = -cmd;
            end
            compare_hold = COMPARE_W'(mag * int'(COMPARE_SCALE));
        end

        s.dir_fwd  = dir_hold;
        s.compare  = compare_hold;
        s.zero     = zero;
        s.busy     = homing_on;
        s.finished = done;
        s.pos_blk  = pos_latch;
        s.neg_blk  = neg_latch;
        return s;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic axis_tick_t build_tick(input int cmd, input logic en, input logic home,
                                              input logic plim, input logic nlim,
                                              input int pos, input logic req);
        axis_tick_t t;
        t.motor_command    = CMD_W'(cmd);
        t.drive_enable     = en;
        t.home_sensor      = home;
        t.pos_limit_sensor = plim;
        t.neg_limit_sensor = nlim;
        t.position         = POS_W'(pos);
        t.home_request     = req;
        return t;
    endfunction

    // commands clustered at the extremes, at zero and around the clamp
    function automatic logic signed [CMD_W-1:0] pick_command();
        int r;
        int lim;
        r   = $urandom_range(0, 99);
        lim = int'(drive_limit_q);
        if (r < 8)
            return CMD_W'(32767);
        else if (r < 16)
            return CMD_W'(-32768);
        else if (r < 24)
            return '0;
        else if (r < 34)
            return CMD_W'(lim + $urandom_range(0, 4) - 2);
        else if (r < 44)
            return CMD_W'(-lim + $urandom_range(0, 4) - 2);
        else if (r < 64)
            return CMD_W'($urandom_range(0, 200) - 100);
        return CMD_W'($urandom);
    endfunction

    // positions on and around a homing threshold
    function automatic logic signed [POS_W-1:0] near_position(input int thr);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return POS_W'(thr + $urandom_range(0, 2) - 1);
        else if (r < 80)
            return POS_W'(thr + $urandom_range(0, 60) - 30);
        return POS_W'($urandom);
    endfunction

    // random tick, steered by the model phase so homing runs to completion
    function automatic axis_tick_t make_tick();
        axis_tick_t t;
        int         r;
        r                  = $urandom_range(0, 99);
        t.motor_command    = pick_command();
        t.drive_enable     = ($urandom_range(0, 99) < 85);
        t.home_sensor      = ($urandom_range(0, 99) < 12);
        t.pos_limit_sensor = ($urandom_range(0, 99) < 10);
        t.neg_limit_sensor = ($urandom_range(0, 99) < 10);
        t.position         = POS_W'($urandom);
        t.home_request     = ($urandom_range(0, 99) < (homing_on ? 20 : 6));

        if (r < 15)
        begin
            // pure noise on every field
            t.motor_command    = CMD_W'($urandom);
            t.drive_enable     = 1'($urandom_range(0, 1));
            t.home_sensor      = 1'($urandom_range(0, 1));
            t.pos_limit_sensor = 1'($urandom_range(0, 1));
            t.neg_limit_sensor = 1'($urandom_range(0, 1));
            t.home_request     = 1'($urandom_range(0, 1));
        end
        else if (homing_on)
        begin
            case (axis_phase)
                PH_JOG:
                begin
                    t.home_sensor      = ($urandom_range(0, 99) < 15);
                    t.pos_limit_sensor = ($urandom_range(0, 99) < 12);
                end
                PH_OVERSHOOT:
                    t.position = near_position(int'(overshoot_q));
                PH_RETURN:
                    t.home_sensor = ($urandom_range(0, 99) < 25);
                default:
                    t.position = near_position(-int'(backoff_q));
            endcase
        end
        return t;
    endfunction

    // one input request: optional gap, then hold until accepted
    task automatic send_tick(input axis_tick_t t);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        motor_command    <= t.motor_command;
        drive_enable     <= t.drive_enable;
        home_sensor      <= t.home_sensor;
        pos_limit_sensor <= t.pos_limit_sensor;
        neg_limit_sensor <= t.neg_limit_sensor;
        position         <= t.position;
        home_request     <= t.home_request;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        pending_status.push_back(step_axis(t));
    endtask

    task automatic send_random(input int count);
        repeat (count) send_tick(make_tick());
    endtask

    // stop sending and wait until every owed status word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // write all four registers back to back while the block is idle
    task automatic program_regs(input int dl, input int hs, input int ov, input int bo);
        cfg_reg_t regs[4];
        int       vals[4];
        int       i;
        regs = '{REG_DRIVE_LIMIT, REG_HOMING_SPEED, REG_OVERSHOOT_COUNTS, REG_BACKOFF_COUNTS};
        vals = '{dl, hs, ov, bo};
        drain_results();
        for (i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= CFG_DATA_W'(vals[i]);
            do
                @(posedge clk);
            while (!cfg_ready);
            case (regs[i])
                REG_DRIVE_LIMIT:      drive_limit_q  = SPEED_W'(vals[i]);
                REG_HOMING_SPEED:     homing_speed_q = SPEED_W'(vals[i]);
                REG_OVERSHOOT_COUNTS: overshoot_q    = COUNT_W'(vals[i]);
                default:              backoff_q      = COUNT_W'(vals[i]);
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // clamp, direction and latched limit blocks with reset registers
    task automatic test_drive_directed();
        send_tick(build_tick(0, 1, 0, 0, 0, 0, 0));          // zero counts as forward
        send_tick(build_tick(32767, 1, 0, 0, 0, 32767, 0));   // clamped to the limit
        send_tick(build_tick(-32768, 1, 0, 0, 0, -32768, 0));
        send_tick(build_tick(8001, 1, 0, 0, 0, 0, 0));
        send_tick(build_tick(-8000, 1, 0, 0, 0, 0, 0));
        send_tick(build_tick(-8001, 1, 0, 0, 0, 0, 0));
        send_tick(build_tick(1, 1, 0, 0, 0, 0, 0));
        send_tick(build_tick(-1, 1, 0, 0, 0, 0, 0));
        send_tick(build_tick(123, 0, 1, 1, 1, -1, 0));        // disabled, everything held
        send_tick(build_tick(100, 1, 0, 1, 0, 0, 0));         // positive limit latches
        send_tick(build_tick(200, 1, 0, 0, 0, 0, 0));         // still blocked
        send_tick(build_tick(-50, 1, 0, 0, 0, 0, 0));         // reverse clears it
        send_tick(build_tick(-50, 1, 0, 0, 1, 0, 0));         // negative limit latches
        send_tick(build_tick(-1, 1, 0, 0, 0, 0, 0));
        send_tick(build_tick(0, 1, 0, 0, 0, 0, 0));           // zero clears negative block
    endtask

    // both homing paths, overlapping requests and finishing while disabled
    task automatic test_homing_directed();
        send_tick(build_tick(-700, 1, 0, 0, 0, 0, 1));        // start, jog at homing speed
        send_tick(build_tick(-700, 1, 0, 0, 0, 0, 1));        // request while busy ignored
        send_tick(build_tick(0, 1, 1, 0, 0, 0, 0));           // home found, zero encoder
        send_tick(build_tick(0, 1, 0, 0, 0, 49, 0));
        send_tick(build_tick(0, 1, 0, 0, 0, 50, 0));          // overshoot reached
        send_tick(build_tick(0, 0, 0, 0, 0, 0, 0));           // return while disabled
        send_tick(build_tick(0, 1, 1, 0, 0, 0, 0));           // finish drives zero
        send_tick(build_tick(500, 1, 0, 1, 0, 0, 1));         // start and hit positive limit
        send_tick(build_tick(500, 1, 0, 0, 0, -299, 0));
        send_tick(build_tick(500, 1, 0, 0, 1, -300, 0));      // back-off reached
        send_tick(build_tick(500, 0, 1, 0, 0, 0, 0));         // finish with drive disabled
        send_tick(build_tick(0, 1, 1, 1, 0, 0, 1));           // home wins over the limit
        send_tick(build_tick(0, 1, 0, 0, 0, 32767, 0));
        send_tick(build_tick(0, 1, 0, 0, 1, -32768, 0));
        send_tick(build_tick(0, 1, 1, 0, 0, 0, 0));
    endtask

    // register extremes and random settings, each with random traffic
    task automatic test_register_sweep();
        program_regs(0, 0, 0, 0);
        send_random(110);
        program_regs(8000, 8000, 32767, 32767);
        send_random(110);
        program_regs(1, 8000, 0, 32767);
        send_random(110);
        program_regs(8000, 0, 32767, 0);
        send_random(110);
        repeat (3)
        begin
            program_regs($urandom_range(0, 8000), $urandom_range(0, 8000),
                         $urandom_range(0, 400), $urandom_range(0, 400));
            send_random(110);
        end
        program_regs(int'(DRIVE_LIMIT_RESET), int'(HOMING_SPEED_RESET),
                     int'(OVERSHOOT_COUNTS_RESET), int'(BACKOFF_COUNTS_RESET));
        send_random(110);
    endtask

    // long random run with a full pause and a stretch without idling
    task automatic test_random_traffic();
        send_random(300);
        drain_results();
        no_idle = 1'b1;
        send_random(150);
        no_idle = 1'b0;
        send_random(450);
    endtask

    task automatic check_field(input string name, input int unsigned expv,
                               input int unsigned actv);
        if (expv != actv)
        begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            mismatches++;
        end
    endtask

    // result checking, result-side stalls and the watchdog share one clocked process
    int idle_cycles = 0;
    int stall_left  = 0;

    always @(posedge clk)
    begin : result_monitor
        drive_status_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_status.size() == 0)
                begin
                    $error("status word with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_status.pop_front();
                    check_field("direction_forward", 32'(want.dir_fwd),
                                32'(direction_forward));
                    check_field("compare_value", 32'(want.compare), 32'(compare_value));
                    check_field("zero_position", 32'(want.zero), 32'(zero_position));
                    check_field("homing_busy", 32'(want.busy), 32'(homing_busy));
                    check_field("homing_finished", 32'(want.finished),
                                32'(homing_finished));
                    check_field("pos_blocked", 32'(want.pos_blk), 32'(pos_blocked));
                    check_field("neg_blocked", 32'(want.neg_blk), 32'(neg_blocked));
                end
            end

            // stall the result side in random bursts
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                stall_left = gap_len();
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left = stall_left - 1;
            end
        end

        // any accepted request on any channel counts as progress
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("axis_homing_and_limited_drive_top_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_drive_directed();
        test_homing_directed();
        test_register_sweep();
        test_random_traffic();
        drain_results();

        if (mismatches == 0 && pending_status.size() == 0)
            $display("axis_homing_and_limited_drive_top_test: PASS");
        else
            $display("axis_homing_and_limited_drive_top_test: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/ahld_pkg.sv
rtl/axis_homing_and_limited_drive_top.sv
tb/axis_homing_and_limited_drive_top_test.sv
